FILE: hdl/pbr_pkg.sv
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared constants, factorial table and the pipeline item type for the
// permutation-by-rank decoder.
// ----------------------------------------------------------------------------
package pbr_pkg;

	localparam int MAX_LEN = 8;
	localparam int LEN_W   = 4;
	localparam int RANK_W  = 16;
	localparam int ELEM_W  = 3;
	localparam int SUM_W   = ELEM_W + 1;
	localparam int PROD_W  = RANK_W + ELEM_W;
	localparam int NUM_DIG = MAX_LEN - 1;
	localparam int NUM_STG = 1 + 2 * NUM_DIG;
	localparam int DATA_W  = MAX_LEN * ELEM_W;

	typedef logic [RANK_W-1:0] rank_t;

	localparam rank_t FACT [0:MAX_LEN] = '{
		RANK_W'(1), RANK_W'(1), RANK_W'(2), RANK_W'(6), RANK_W'(24),
		RANK_W'(120), RANK_W'(720), RANK_W'(5040), RANK_W'(40320)
	};

	typedef struct packed {
		logic [LEN_W-1:0]                len;
		logic                            too_big;
		rank_t                           rem;
		logic [NUM_DIG-1:0][ELEM_W-1:0]  dig;   // dig[i] is the digit of level i+2
		logic [MAX_LEN-1:0][ELEM_W-1:0]  row;
	} pbr_item_t;

	// k * (level-1)!
	function automatic logic [PROD_W-1:0] fact_mul(input logic [LEN_W-1:0] level,
			input logic [ELEM_W-1:0] k);
		logic [LEN_W-1:0] idx;
		idx = level - LEN_W'(1);
		return PROD_W'(FACT[idx]) * PROD_W'(k);
	endfunction

endpackage

FILE: hdl/permutation_by_rank_core.sv
// Pipeline: 15 register stages (1 input register, 7 digit-split levels,
// 7 row-build levels).
// Throughput: one item per cycle; every stage register holds while its
// successor is full and blocked, bubbles collapse.
// Reset: arst_n clears all valid bits and sets perm_length to 8.
// ----------------------------------------------------------------------------
// permutation_by_rank_core
// Decodes a rank into the permutation of that rank for the configured
// length, one item per cycle unless the output stalls, through a level-per-stage pipeline.
// ----------------------------------------------------------------------------
module permutation_by_rank_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [pbr_pkg::LEN_W-1:0]    cfg_wr_data,   // perm_length
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [pbr_pkg::RANK_W-1:0]   s_tdata,       // [15:0] rank
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [pbr_pkg::DATA_W-1:0]   m_tdata,       // elem0..elem7, 3 bits each
	output logic [0:0]                   m_tuser        // [0] rank_too_big
);
	import pbr_pkg::*;

	logic [LEN_W-1:0]     perm_length_q;
	logic [LEN_W-1:0]     len_eff;
	logic                 valid_s1;
	pbr_item_t            item_s1;
	pbr_item_t            item_in;
	logic [NUM_STG-1:0]   st_valid;
	pbr_item_t            st_item [0:NUM_STG-1];
	logic [NUM_STG:0]     adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_length_q <= LEN_W'(MAX_LEN);
		end else if (cfg_wr_en) begin
			perm_length_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (perm_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (perm_length_q > LEN_W'(MAX_LEN)) begin
			len_eff = LEN_W'(MAX_LEN);
		end else begin
			len_eff = perm_length_q;
		end
		item_in         = '0;
		item_in.len     = len_eff;
		item_in.rem     = s_tdata;
		item_in.too_big = (s_tdata >= FACT[len_eff]);
	end

	always_comb begin
		adv[NUM_STG] = m_tready;
		for (int k = NUM_STG - 1; k >= 0; k--) begin
			adv[k] = !st_valid[k] || adv[k+1];
		end
	end

	assign s_tready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv[0]) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			item_s1 <= item_in;
		end
	end

	assign st_valid[0] = valid_s1;
	assign st_item[0]  = item_s1;

	for (genvar g = 0; g < NUM_DIG; g++) begin : g_dig
		pbr_digit_stage u_dig (
			.clk       (clk),
			.arst_n    (arst_n),
			.level     (LEN_W'(MAX_LEN - g)),
			.adv       (adv[1+g]),
			.in_valid  (st_valid[g]),
			.in_item   (st_item[g]),
			.out_valid (st_valid[1+g]),
			.out_item  (st_item[1+g])
		);
	end

	for (genvar g = 0; g < NUM_DIG; g++) begin : g_bld
		pbr_build_stage u_bld (
			.clk       (clk),
			.arst_n    (arst_n),
			.level     (LEN_W'(2 + g)),
			.adv       (adv[1+NUM_DIG+g]),
			.in_valid  (st_valid[NUM_DIG+g]),
			.in_item   (st_item[NUM_DIG+g]),
			.out_valid (st_valid[1+NUM_DIG+g]),
			.out_item  (st_item[1+NUM_DIG+g])
		);
	end

	assign m_tvalid   = st_valid[NUM_STG-1];
	assign m_tdata    = st_item[NUM_STG-1].too_big ? '0 : DATA_W'(st_item[NUM_STG-1].row);
	assign m_tuser[0] = st_item[NUM_STG-1].too_big;

	a_too_big_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("out-of-range item carries nonzero elements");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	a_range_flag: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata >= FACT[MAX_LEN] |=> valid_s1 && item_s1.too_big)
		else $error("rank above max factorial not flagged");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st_item[NUM_STG-1].len < LEN_W'(MAX_LEN) |->
			st_item[NUM_STG-1].row[MAX_LEN-1] == '0)
		else $error("element beyond length is nonzero");

endmodule

FILE: hdl/pbr_digit_stage.sv
// ----------------------------------------------------------------------------
// pbr_digit_stage
// One level of the factorial-base split: digit = rem / (level-1)!,
// rem = rem mod (level-1)!, by parallel compares against constant multiples.
// ----------------------------------------------------------------------------
module pbr_digit_stage (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [pbr_pkg::LEN_W-1:0] level,
	input  logic                     adv,
	input  logic                     in_valid,
	input  pbr_pkg::pbr_item_t       in_item,
	output logic                     out_valid,
	output pbr_pkg::pbr_item_t       out_item
);
	import pbr_pkg::*;

	logic              valid_q;
	pbr_item_t         item_q;
	pbr_item_t         nxt;
	logic [ELEM_W-1:0] d;
	logic [PROD_W-1:0] sub;

	always_comb begin
		nxt = in_item;
		d   = '0;
		for (int k = 1; k <= NUM_DIG; k++) begin
			if (LEN_W'(k) < level &&
					PROD_W'(in_item.rem) >= fact_mul(level, ELEM_W'(k))) begin
				d = ELEM_W'(k);
			end
		end
		sub     = fact_mul(level, d);
		nxt.rem = in_item.rem - sub[RANK_W-1:0];
		for (int i = 0; i < NUM_DIG; i++) begin
			if (LEN_W'(i + 2) == level) begin
				nxt.dig[i] = d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

FILE: hdl/pbr_build_stage.sv
// ----------------------------------------------------------------------------
// pbr_build_stage
// One level of the row build: row of length level from row of length
// level-1 and this level's digit. Passes the row through above the length.
// ----------------------------------------------------------------------------
module pbr_build_stage (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [pbr_pkg::LEN_W-1:0] level,
	input  logic                     adv,
	input  logic                     in_valid,
	input  pbr_pkg::pbr_item_t       in_item,
	output logic                     out_valid,
	output pbr_pkg::pbr_item_t       out_item
);
	import pbr_pkg::*;

	logic              valid_q;
	pbr_item_t         item_q;
	pbr_item_t         nxt;
	logic [ELEM_W-1:0] j;
	logic [SUM_W-1:0]  s;

	always_comb begin
		nxt = in_item;
		j   = '0;
		s   = '0;
		for (int i = 0; i < NUM_DIG; i++) begin
			if (LEN_W'(i + 2) == level) begin
				j = in_item.dig[i];
			end
		end
		if (level <= in_item.len) begin
			nxt.row[0] = j;
			for (int m = 0; m < MAX_LEN - 1; m++) begin
				s = SUM_W'(in_item.row[m]) + SUM_W'(j) + SUM_W'(1);
				if (s >= SUM_W'(level)) begin
					s = s - SUM_W'(level);
				end
				nxt.row[m+1] = (LEN_W'(m + 1) < level) ? s[ELEM_W-1:0] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

FILE: tb/permutation_by_rank_core_tb.sv
// ----------------------------------------------------------------------------
// permutation_by_rank_core_tb
// Sends ranks through the decoder under several permutation lengths and
// checks every output item against a behavioral decode of the same rank.
// The input side runs in random bursts and the output side stalls on its
// own pattern. The length register is only written when no result is pending.
// ----------------------------------------------------------------------------
module permutation_by_rank_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import pbr_pkg::*;

	localparam int unsigned FACT_LUT [0:8] = '{1, 1, 2, 6, 24, 120, 720, 5040, 40320};

	typedef enum logic [1:0] {STEP_RANK, STEP_LEN, STEP_DRAIN} step_kind_e;

	typedef struct {
		step_kind_e        kind;
		logic [RANK_W-1:0] rank;
		logic [LEN_W-1:0]  len;
	} step_t;

	typedef struct packed {
		logic [MAX_LEN-1:0][ELEM_W-1:0] elem;
		logic                           too_big;
	} perm_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [LEN_W-1:0]    cfg_wr_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [RANK_W-1:0]   s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;
	logic [0:0]          m_tuser;

	step_t               step_q[$];
	perm_row_t           row_q[$];
	logic [LEN_W-1:0]    len_mirror = LEN_W'(8);
	logic                taken = 1'b0;
	int                  err_count = 0;
	int                  burst_left = 1;
	int                  gap_left = 0;
	int                  rx_mode = 0;
	int                  rx_left = 0;
	int                  rx_phase = 0;

	permutation_by_rank_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always #10 clk = ~clk;

	function automatic int unsigned eff_length(input logic [LEN_W-1:0] len_reg);
		int unsigned n;
		n = len_reg;
		if (n < 1) n = 1;
		if (n > MAX_LEN) n = MAX_LEN;
		return n;
	endfunction

	function automatic perm_row_t decode_rank(input logic [RANK_W-1:0] rank,
			input logic [LEN_W-1:0] len_reg);
		int unsigned n;
		int unsigned r;
		int unsigned j;
		int unsigned dig [0:MAX_LEN];
		int unsigned row [0:MAX_LEN-1];
		int unsigned nxt [0:MAX_LEN-1];
		int          i;
		int          m;
		perm_row_t   res;
		n = eff_length(len_reg);
		r = rank;
		res = '0;
		if (r >= FACT_LUT[n]) begin
			res.too_big = 1'b1;
			return res;
		end
		for (i = 0; i < MAX_LEN; i++) begin
			row[i] = 0;
			nxt[i] = 0;
		end
		for (i = int'(n); i >= 2; i--) begin
			dig[i] = r / FACT_LUT[i-1];
			r = r % FACT_LUT[i-1];
		end
		for (i = 2; i <= int'(n); i++) begin
			j = dig[i];
			nxt[0] = j;
			for (m = 0; m + 1 < i; m++)
				nxt[m+1] = (row[m] + 1 + j) % i;
			for (m = 0; m < i; m++)
				row[m] = nxt[m];
		end
		for (m = 0; m < int'(n); m++)
			res.elem[m] = ELEM_W'(row[m]);
		return res;
	endfunction

	function automatic logic [RANK_W-1:0] pick_rank(input logic [LEN_W-1:0] len_reg);
		int unsigned lim;
		int unsigned sel;
		lim = FACT_LUT[eff_length(len_reg)];
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return RANK_W'($urandom_range(0, 65535));
		if (sel < 3)
			return RANK_W'($urandom_range(lim, 65535));
		if (sel == 3)
			return RANK_W'(lim - 1);
		return RANK_W'($urandom_range(0, lim - 1));
	endfunction

	task automatic add_rank(input logic [RANK_W-1:0] rank);
		step_t s;
		s.kind = STEP_RANK;
		s.rank = rank;
		s.len = '0;
		step_q.push_back(s);
	endtask

	task automatic add_len(input logic [LEN_W-1:0] len);
		step_t s;
		s.kind = STEP_LEN;
		s.rank = '0;
		s.len = len;
		step_q.push_back(s);
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// sender: bursts and gaps; length writes and drains wait for an empty pipe
	always @(negedge clk) begin
		logic              vld_n;
		logic [RANK_W-1:0] dat_n;
		logic              wen_n;
		step_t             s;
		vld_n = s_tvalid;
		dat_n = s_tdata;
		wen_n = 1'b0;
		if (arst_n && (!s_tvalid || taken)) begin
			vld_n = 1'b0;
			if (step_q.size() > 0 && step_q[0].kind != STEP_RANK) begin
				if (row_q.size() == 0) begin
					s = step_q.pop_front();
					if (s.kind == STEP_LEN) begin
						wen_n = 1'b1;
						cfg_wr_data <= s.len;
					end
				end
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (step_q.size() > 0) begin
				s = step_q.pop_front();
				vld_n = 1'b1;
				dat_n = s.rank;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
		end
		s_tvalid <= vld_n;
		s_tdata <= dat_n;
		cfg_wr_en <= wen_n;
	end

	// receiver: always ready, random stalls, or long periodic stalls
	always @(negedge clk) begin
		logic rdy;
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(20, 300);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			0: rdy = 1'b1;
			1: rdy = ($urandom_range(0, 3) != 0);
			default: rdy = ((rx_phase % 24) < 6);
		endcase
		m_tready <= rdy;
	end

	always @(posedge clk) begin
		perm_row_t got;
		perm_row_t want;
		int        m;
		taken <= s_tvalid && s_tready;
		if (cfg_wr_en)
			len_mirror = cfg_wr_data;
		if (arst_n && s_tvalid && s_tready)
			row_q.push_back(decode_rank(s_tdata, len_mirror));
		if (arst_n && m_tvalid && m_tready) begin
			for (m = 0; m < MAX_LEN; m++)
				got.elem[m] = m_tdata[m*ELEM_W +: ELEM_W];
			got.too_big = m_tuser[0];
			if (row_q.size() == 0) begin
				flag_mismatch("result with none expected", int'(got.too_big), -1);
			end else begin
				want = row_q.pop_front();
				for (m = 0; m < MAX_LEN; m++)
					if (got.elem[m] !== want.elem[m])
						flag_mismatch($sformatf("elem%0d", m), int'(got.elem[m]),
							int'(want.elem[m]));
				if (got.too_big !== want.too_big)
					flag_mismatch("rank_too_big", int'(got.too_big), int'(want.too_big));
			end
		end
	end

	initial begin
		int               total;
		int               cnt;
		int               k;
		int               phase;
		logic [LEN_W-1:0] len;
		step_t            s;

		// reset length is 8
		add_rank(16'd0);
		add_rank(16'd1);
		add_rank(16'd40319);
		add_rank(16'd40320);
		add_rank(16'd65535);
		add_rank(16'd5040);
		add_rank(16'd32768);
		add_len(4'd1);
		add_rank(16'd0);
		add_rank(16'd1);
		add_rank(16'd65535);
		add_len(4'd0);
		add_rank(16'd0);
		add_rank(16'd1);
		add_len(4'd15);
		add_rank(16'd40319);
		add_rank(16'd40320);
		add_len(4'd2);
		add_rank(16'd0);
		add_rank(16'd1);
		add_rank(16'd2);
		add_len(4'd9);
		add_rank(16'd40319);
		add_len(4'd3);
		add_rank(16'd5);
		add_rank(16'd6);

		total = 0;
		phase = 0;
		while (total < 1525) begin
			if ($urandom_range(0, 4) == 0)
				len = LEN_W'($urandom_range(0, 15));
			else
				len = LEN_W'($urandom_range(1, 8));
			add_len(len);
			cnt = $urandom_range(60, 140);
			for (k = 0; k < cnt; k++) begin
				if (phase == 0 && k == cnt / 2) begin
					s.kind = STEP_DRAIN;
					s.rank = '0;
					s.len = '0;
					step_q.push_back(s);
				end
				add_rank(pick_rank(len));
				total++;
			end
			phase++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (step_q.size() > 0 || s_tvalid || row_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("permutation_by_rank_core test passed");
		else
			$display("permutation_by_rank_core test failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("permutation_by_rank_core test failed");
		$finish;
	end

endmodule
